// ===== rtl/core/ist_pkg.sv =====
// Shared types and constants for the integer set table.
// Used by integer_set_table; no dependencies.
`timescale 1ns / 1ps

package ist_pkg;

	// Default number of entries in the set.
	localparam int CAPACITY_DEF = 64;

	// Field widths.
	localparam int REQ_W   = 3;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;

	// Largest value the member count field can show.
	localparam int COUNT_MAX = (1 << COUNT_W) - 1;

	// One memory word holds a valid mark above the stored value.
	localparam int ENTRY_W = VALUE_W + 1;

	// Request codes. The three unused codes behave as a find.
	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_ERASE  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FIND   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_TOGGLE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

	// Control sequencer states.
	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

endpackage

// ===== rtl/core/ist_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; no package dependencies.
`timescale 1ns / 1ps

module ist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/integer_set_table.sv =====
// Top level of the integer set table: a bounded set of distinct 32-bit values.
// Depends on ist_pkg and the ist_ram entry memory.
`timescale 1ns / 1ps

// The set lives in one entry memory of CAPACITY words, each a valid mark and a
// value. An insert, erase, find or toggle scans every entry through the memory's
// single read port, one entry per cycle, then writes back at most one entry, and
// the next item is taken in the cycle after the result is registered. A clear of
// an empty set goes straight to the write-back state; a clear of a non-empty set
// first sweeps all CAPACITY entries, one write per cycle, then answers from the
// write-back state. After reset the same clearing sweep runs over all CAPACITY
// entries, and no item is accepted until it ends. A new member takes the lowest
// free entry. A finished result waits in an output register while the next item
// is accepted.

module integer_set_table #(
	parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [ist_pkg::REQ_W-1:0]         req_type,
	input  logic signed [ist_pkg::VALUE_W-1:0] value,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic                              was_present,
	output logic                              changed,
	output logic                              table_full,
	output logic [ist_pkg::COUNT_W-1:0]       member_count
);

	import ist_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [AW:0] IDX_END  = (AW + 1)'(CAPACITY);
	localparam logic [AW:0] IDX_LAST = (AW + 1)'(CAPACITY - 1);

	state_t state_q, state_d;

	// Request and scan registers.
	logic [REQ_W-1:0]   op_q;
	logic [VALUE_W-1:0] value_q;
	logic [AW:0]        idx_q;
	logic               sweep_reply_q;
	logic               cmp_valid_s1;
	logic [AW-1:0]      cmp_idx_s1;
	logic               hit_q;
	logic [AW-1:0]      hit_idx_q;
	logic               free_found_q;
	logic [AW-1:0]      free_idx_q;
	logic [CW-1:0]      count_q;

	// Output registers.
	logic               rsp_valid_q;
	logic               was_present_q;
	logic               changed_q;
	logic               table_full_q;
	logic [COUNT_W-1:0] member_count_q;

	// Memory port signals.
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	// Result of the write-back step.
	logic               res_present;
	logic               res_changed;
	logic               res_full;
	logic [CW-1:0]      count_next;
	logic [31:0]        count_wide;

	logic req_fire;
	logic out_free;
	logic entry_hit;
	logic entry_free;

	assign req_fire = req_valid && req_ready;
	assign out_free = !rsp_valid_q || rsp_ready;

	// Entry memory: valid mark in the top bit, value below it.
	ist_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				if (idx_q == IDX_LAST) begin
					state_d = sweep_reply_q ? ST_WRITE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					if (req_type == REQ_CLEAR) begin
						state_d = (count_q != '0) ? ST_SWEEP : ST_WRITE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (idx_q == IDX_END && cmp_valid_s1) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output logic: memory accesses and the write-back decision.
	always_comb begin
		req_ready   = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = idx_q[AW-1:0];
		ram_wdata   = '0;
		ram_re      = 1'b0;
		ram_raddr   = idx_q[AW-1:0];
		res_present = 1'b0;
		res_changed = 1'b0;
		res_full    = 1'b0;
		count_next  = count_q;
		unique case (state_q)
			ST_SWEEP: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_SCAN: begin
				ram_re = (idx_q < IDX_END);
			end
			ST_WRITE: begin
				if (op_q == REQ_CLEAR) begin
					res_changed = (count_q != '0);
					count_next  = '0;
				end else begin
					res_present = hit_q;
					if ((op_q == REQ_ERASE || op_q == REQ_TOGGLE) && hit_q) begin
						ram_we      = out_free;
						ram_waddr   = hit_idx_q;
						ram_wdata   = {1'b0, value_q};
						res_changed = 1'b1;
						count_next  = count_q - CW'(1);
					end else if ((op_q == REQ_INSERT || op_q == REQ_TOGGLE) && !hit_q) begin
						if (free_found_q) begin
							ram_we      = out_free;
							ram_waddr   = free_idx_q;
							ram_wdata   = {1'b1, value_q};
							res_changed = 1'b1;
							count_next  = count_q + CW'(1);
						end else begin
							res_full = 1'b1;
						end
					end
				end
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	// Member count as shown, saturated to the field.
	assign count_wide = 32'(count_next);

	// Compare the entry returned by the memory.
	assign entry_hit  = ram_rdata[VALUE_W] && (ram_rdata[VALUE_W-1:0] == value_q);
	assign entry_free = !ram_rdata[VALUE_W];

	// Sequencer, scan and count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_SWEEP;
			idx_q         <= '0;
			sweep_reply_q <= 1'b0;
			cmp_valid_s1  <= 1'b0;
			hit_q         <= 1'b0;
			free_found_q  <= 1'b0;
			count_q       <= '0;
		end else begin
			state_q      <= state_d;
			cmp_valid_s1 <= ram_re;
			if (req_fire) begin
				idx_q         <= '0;
				sweep_reply_q <= 1'b1;
				hit_q         <= 1'b0;
				free_found_q  <= 1'b0;
			end else if ((state_q == ST_SWEEP) || ram_re) begin
				idx_q <= idx_q + (AW + 1)'(1);
			end
			if (cmp_valid_s1) begin
				if (entry_hit && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (entry_free && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			if (state_q == ST_WRITE && out_free) begin
				count_q <= count_next;
			end
		end
	end

	// Scan payload registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q    <= req_type;
			value_q <= value;
		end
		cmp_idx_s1 <= idx_q[AW-1:0];
		if (cmp_valid_s1 && entry_hit && !hit_q) begin
			hit_idx_q <= cmp_idx_s1;
		end
		if (cmp_valid_s1 && entry_free && !free_found_q) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_WRITE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE && out_free) begin
			was_present_q  <= res_present;
			changed_q      <= res_changed;
			table_full_q   <= res_full;
			member_count_q <= (count_wide > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
				: count_wide[COUNT_W-1:0];
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign was_present  = was_present_q;
	assign changed      = changed_q;
	assign table_full   = table_full_q;
	assign member_count = member_count_q;

	// The member count never exceeds the number of entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAPACITY)
		else $error("member count exceeds capacity");

	// Memory compares happen only during a scan.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmp_valid_s1 |-> (state_q == ST_SCAN))
		else $error("entry compare outside a scan");

	// A write-back returns to idle in the next cycle, with the result valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && ram_we) |=> (state_q == ST_IDLE && rsp_valid_q))
		else $error("write-back did not complete the item");

	// A refused insert or toggle neither found the value nor changed the set.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && table_full_q) |-> (!changed_q && !was_present_q))
		else $error("full flag with a change or a prior member");

endmodule
